>>> hw/rtl/trt_pkg.sv
// Shared types, codes and constants of the throttled request tracker.
`default_nettype none
package trt_pkg;

    // Default sizes of the two tables
    localparam int PENDING_DEPTH_DEF  = 32;
    localparam int PRIORITY_DEPTH_DEF = 64;

    // Field widths
    localparam int ITEM_W  = 32;
    localparam int WAIT_W  = 12;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    // Request types
    localparam logic [2:0] REQ_TRACK   = 3'd0;
    localparam logic [2:0] REQ_FILL    = 3'd1;
    localparam logic [2:0] REQ_REJECT  = 3'd2;
    localparam logic [2:0] REQ_TICK    = 3'd3;
    localparam logic [2:0] REQ_CLR_PRI = 3'd4;
    localparam logic [2:0] REQ_ADD_PRI = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_ISSUE = 2'd0;
    localparam logic [1:0] KIND_IMPL  = 2'd1;
    localparam logic [1:0] KIND_EXPL  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    // Emit source select
    localparam logic [1:0] EM_HIT   = 2'd0;
    localparam logic [1:0] EM_DROP  = 2'd1;
    localparam logic [1:0] EM_ISSUE = 2'd2;
    localparam logic [1:0] EM_FIN   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 8'd3;

    // Configuration reset values
    localparam logic [15:0]       SETTLE_RST   = 16'd1000;
    localparam logic [15:0]       SPACING_RST  = 16'd50;
    localparam logic [3:0]        BUDGET_RST   = 4'd6;
    localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 12'd1200;
    localparam logic [WAIT_W-1:0] WAIT_SAT     = 12'd4095;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ITEM_W-1:0] item_id;
        logic              implicit;
        logic              cache_hit;
        logic [31:0]       now_ms;
        logic              in_world;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [ITEM_W-1:0] out_item;
        logic              success;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [WAIT_W-1:0] wait_cnt;
        logic              issued;
        logic              implicit;
        logic              failed;
        logic              loaded;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       clr_idx;
        logic       inc_idx;
        logic       ent_rd;
        logic       ent_rd_last;
        logic       ent_wr_match;
        logic       ent_append;
        logic       ent_wb;
        logic       ent_move;
        logic       load_e;
        logic       gate_upd;
        logic       tick_setup;
        logic       clr_pidx;
        logic       inc_pidx;
        logic       pri_rd;
        logic       pri_found;
        logic       pri_append;
        logic       pri_clear;
        logic       issue;
        logic       dec_count;
        logic       emit;
        logic [1:0] emit_sel;
        logic       flush;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       hit;
        logic       impl;
        logic       item_zero;
        logic       idx_end;
        logic       idx_is_last;
        logic       ent_match;
        logic       ent_full;
        logic       count_zero;
        logic       pidx_end;
        logic       pri_match;
        logic       pri_full;
        logic       gate_open;
        logic       e_issued;
        logic       e_loaded;
        logic       e_failed;
        logic       e_timeout;
        logic       go;
        logic       hold_valid;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/trt_ctrl.sv
// Controller state machine of the request tracker.
`default_nettype none
module trt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 busy,
    input  wire trt_pkg::status_t st,
    output trt_pkg::cmd_t        cmd
);
    import trt_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_EMIT_HIT  = 5'd2;
    localparam logic [4:0] S_SRCH_RD   = 5'd3;
    localparam logic [4:0] S_SRCH_CMP  = 5'd4;
    localparam logic [4:0] S_SRCH_MISS = 5'd5;
    localparam logic [4:0] S_EMIT_DROP = 5'd6;
    localparam logic [4:0] S_FLUSH     = 5'd7;
    localparam logic [4:0] S_GATE      = 5'd8;
    localparam logic [4:0] S_GATE2     = 5'd9;
    localparam logic [4:0] S_T_RD      = 5'd10;
    localparam logic [4:0] S_T_LOAD    = 5'd11;
    localparam logic [4:0] S_T_CHK     = 5'd12;
    localparam logic [4:0] S_P_RD      = 5'd13;
    localparam logic [4:0] S_P_CMP     = 5'd14;
    localparam logic [4:0] S_T_GO      = 5'd15;
    localparam logic [4:0] S_EMIT_ISS  = 5'd16;
    localparam logic [4:0] S_T_FIN     = 5'd17;
    localparam logic [4:0] S_T_MV      = 5'd18;
    localparam logic [4:0] S_T_MVW     = 5'd19;
    localparam logic [4:0] S_EMIT_FIN  = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       is_add;

    assign busy   = (state_reg != S_IDLE);
    assign is_add = (st.req_type == REQ_ADD_PRI);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.req_type)
                    REQ_TRACK:
                    begin
                        if (st.hit)
                            state_next = st.impl ? S_FLUSH : S_EMIT_HIT;
                        else
                        begin
                            cmd.clr_idx = 1'b1;
                            state_next  = S_SRCH_RD;
                        end
                    end
                    REQ_FILL, REQ_REJECT:
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = S_SRCH_RD;
                    end
                    REQ_TICK:
                        state_next = S_GATE;
                    REQ_CLR_PRI:
                    begin
                        cmd.pri_clear = 1'b1;
                        state_next    = S_FLUSH;
                    end
                    REQ_ADD_PRI:
                    begin
                        if (st.item_zero)
                            state_next = S_FLUSH;
                        else
                        begin
                            cmd.clr_pidx = 1'b1;
                            state_next   = S_P_RD;
                        end
                    end
                    default:
                        state_next = S_FLUSH;
                endcase
            end
            S_EMIT_HIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_HIT;
                    state_next   = S_FLUSH;
                end
            end
            S_SRCH_RD:
            begin
                if (st.idx_end)
                    state_next = S_SRCH_MISS;
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (st.ent_match)
                begin
                    cmd.ent_wr_match = 1'b1;
                    state_next       = S_FLUSH;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SRCH_MISS:
            begin
                if (st.req_type != REQ_TRACK)
                    state_next = S_FLUSH;
                else if (st.ent_full)
                    state_next = S_EMIT_DROP;
                else
                begin
                    cmd.ent_append = 1'b1;
                    state_next     = S_FLUSH;
                end
            end
            S_EMIT_DROP:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_DROP;
                    state_next   = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!st.hold_valid)
                    state_next = S_IDLE;
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GATE:
            begin
                cmd.gate_upd = 1'b1;
                state_next   = S_GATE2;
            end
            S_GATE2:
            begin
                if (st.count_zero)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.tick_setup = 1'b1;
                    cmd.clr_idx    = 1'b1;
                    state_next     = S_T_RD;
                end
            end
            S_T_RD:
            begin
                if (st.idx_end)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_T_LOAD;
                end
            end
            S_T_LOAD:
            begin
                cmd.load_e = 1'b1;
                state_next = S_T_CHK;
            end
            S_T_CHK:
            begin
                if (st.gate_open && !st.e_issued)
                begin
                    cmd.clr_pidx = 1'b1;
                    state_next   = S_P_RD;
                end
                else
                    state_next = S_T_FIN;
            end
            S_P_RD:
            begin
                if (st.pidx_end)
                begin
                    if (is_add)
                    begin
                        cmd.pri_append = !st.pri_full;
                        state_next     = S_FLUSH;
                    end
                    else
                        state_next = S_T_GO;
                end
                else
                begin
                    cmd.pri_rd = 1'b1;
                    state_next = S_P_CMP;
                end
            end
            S_P_CMP:
            begin
                if (st.pri_match)
                begin
                    cmd.pri_found = 1'b1;
                    state_next    = is_add ? S_FLUSH : S_T_GO;
                end
                else
                begin
                    cmd.inc_pidx = 1'b1;
                    state_next   = S_P_RD;
                end
            end
            S_T_GO:
            begin
                if (st.go)
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_EMIT_ISS;
                end
                else
                    state_next = S_T_FIN;
            end
            S_EMIT_ISS:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_ISSUE;
                    state_next   = S_T_FIN;
                end
            end
            S_T_FIN:
            begin
                if (st.e_loaded || st.e_failed || st.e_timeout)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_T_MV;
                end
                else
                begin
                    cmd.ent_wb  = 1'b1;
                    cmd.inc_idx = 1'b1;
                    state_next  = S_T_RD;
                end
            end
            S_T_MV:
            begin
                if (st.idx_is_last)
                    state_next = S_EMIT_FIN;
                else
                begin
                    cmd.ent_rd_last = 1'b1;
                    state_next      = S_T_MVW;
                end
            end
            S_T_MVW:
            begin
                cmd.ent_move = 1'b1;
                state_next   = S_EMIT_FIN;
            end
            S_EMIT_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_FIN;
                    state_next   = S_T_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/trt_dp.sv
// Datapath of the request tracker: tables, counters, timing state, result buffers.
`default_nettype none
module trt_dp #(
    parameter int PENDING_DEPTH  = trt_pkg::PENDING_DEPTH_DEF,
    parameter int PRIORITY_DEPTH = trt_pkg::PRIORITY_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire trt_pkg::in_item_t                 in_data,
    output trt_pkg::out_item_t                     out_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    input  wire logic                              cfg_wr_en,
    input  wire logic [trt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [trt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire trt_pkg::cmd_t                     cmd,
    output trt_pkg::status_t                       st
);
    import trt_pkg::*;

    localparam int EIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int ECW = $clog2(PENDING_DEPTH + 1);
    localparam int PIW = (PRIORITY_DEPTH > 1) ? $clog2(PRIORITY_DEPTH) : 1;
    localparam int PCW = $clog2(PRIORITY_DEPTH + 1);

    // Configuration
    logic [15:0]       settle_reg;
    logic [15:0]       spacing_reg;
    logic [3:0]        budget_cfg_reg;
    logic [WAIT_W-1:0] max_wait_reg;

    // Control and timing state
    logic [ECW-1:0]    count_reg;
    logic [ECW-1:0]    idx_reg;
    logic [PCW-1:0]    pcount_reg;
    logic [PCW-1:0]    pidx_reg;
    logic              gate_reg;
    logic [31:0]       world_since_reg;
    logic [31:0]       last_issue_reg;
    logic [3:0]        budget_reg;
    logic              bg_reg;
    logic              pri_reg;
    logic              hold_valid_reg;
    logic              out_valid_reg;

    // Payload registers
    in_item_t          req_reg;
    entry_t            e_reg;
    out_item_t         hold_reg;
    out_item_t         out_reg;

    // Memories
    entry_t            ent_mem [PENDING_DEPTH];
    entry_t            ent_rdata_reg;
    logic [ITEM_W-1:0] pri_mem [PRIORITY_DEPTH];
    logic [ITEM_W-1:0] pri_rdata_reg;

    logic              ent_we;
    logic [EIW-1:0]    ent_waddr;
    entry_t            ent_wdata;
    logic [EIW-1:0]    ent_raddr;
    entry_t            match_word;
    entry_t            wb_word;
    entry_t            new_word;
    out_item_t         emit_word;
    out_item_t         push_word;
    logic [31:0]       ws_eff;
    logic [31:0]       settle_dt;
    logic [31:0]       spacing_dt;
    logic [ITEM_W-1:0] pri_key;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Entry updates for the various write sources
    always_comb
    begin
        match_word = ent_rdata_reg;
        case (req_reg.req_type)
            REQ_TRACK:  match_word.implicit = ent_rdata_reg.implicit & req_reg.implicit;
            REQ_FILL:   match_word.loaded   = 1'b1;
            REQ_REJECT: match_word.failed   = 1'b1;
            default:    match_word          = ent_rdata_reg;
        endcase

        wb_word = e_reg;
        if (e_reg.issued && e_reg.wait_cnt != WAIT_SAT)
            wb_word.wait_cnt = e_reg.wait_cnt + WAIT_W'(1);

        new_word          = '0;
        new_word.item     = req_reg.item_id;
        new_word.implicit = req_reg.implicit;
    end

    // Entry memory write and read port selection
    always_comb
    begin
        ent_we    = cmd.ent_wr_match | cmd.ent_append | cmd.ent_wb | cmd.ent_move;
        ent_waddr = idx_reg[EIW-1:0];
        ent_wdata = ent_rdata_reg;
        if (cmd.ent_wr_match)
            ent_wdata = match_word;
        else if (cmd.ent_append)
        begin
            ent_waddr = count_reg[EIW-1:0];
            ent_wdata = new_word;
        end
        else if (cmd.ent_wb)
            ent_wdata = wb_word;
        ent_raddr = cmd.ent_rd_last ? count_reg[EIW-1:0] : idx_reg[EIW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (cmd.ent_rd || cmd.ent_rd_last)
            ent_rdata_reg <= ent_mem[ent_raddr];
    end

    // Priority set memory
    always_ff @(posedge clk)
    begin
        if (cmd.pri_append)
            pri_mem[pcount_reg[PIW-1:0]] <= req_reg.item_id;
        if (cmd.pri_rd)
            pri_rdata_reg <= pri_mem[pidx_reg[PIW-1:0]];
    end

    // Gate and spacing arithmetic
    always_comb
    begin
        ws_eff = world_since_reg;
        if (req_reg.in_world && world_since_reg == 32'd0)
            ws_eff = req_reg.now_ms;
        settle_dt  = req_reg.now_ms - ws_eff;
        spacing_dt = req_reg.now_ms - last_issue_reg;
    end

    // Result word selection
    always_comb
    begin
        emit_word      = '0;
        emit_word.last = 1'b0;
        case (cmd.emit_sel)
            EM_HIT:
            begin
                emit_word.out_kind = KIND_EXPL;
                emit_word.out_item = req_reg.item_id;
                emit_word.success  = 1'b1;
            end
            EM_DROP:
            begin
                emit_word.out_kind = KIND_DROP;
                emit_word.out_item = req_reg.item_id;
            end
            EM_ISSUE:
            begin
                emit_word.out_kind = KIND_ISSUE;
                emit_word.out_item = e_reg.item;
            end
            default:
            begin
                emit_word.out_kind = e_reg.implicit ? KIND_IMPL : KIND_EXPL;
                emit_word.out_item = e_reg.item;
                emit_word.success  = e_reg.loaded;
            end
        endcase
    end

    // Word moved from hold to the output register; a flush marks the end of the transaction
    always_comb
    begin
        push_word      = hold_reg;
        push_word.last = cmd.flush;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg      <= SETTLE_RST;
            spacing_reg     <= SPACING_RST;
            budget_cfg_reg  <= BUDGET_RST;
            max_wait_reg    <= MAX_WAIT_RST;
            count_reg       <= '0;
            idx_reg         <= '0;
            pcount_reg      <= '0;
            pidx_reg        <= '0;
            gate_reg        <= 1'b0;
            world_since_reg <= '0;
            last_issue_reg  <= '0;
            budget_reg      <= '0;
            bg_reg          <= 1'b0;
            pri_reg         <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SETTLE:   settle_reg     <= cfg_wdata;
                    CFG_SPACING:  spacing_reg    <= cfg_wdata;
                    CFG_BUDGET:   budget_cfg_reg <= cfg_wdata[3:0];
                    CFG_MAX_WAIT: max_wait_reg   <= cfg_wdata[WAIT_W-1:0];
                    default:      ;
                endcase
            end

            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + ECW'(1);

            if (cmd.ent_append)
                count_reg <= count_reg + ECW'(1);
            else if (cmd.dec_count)
                count_reg <= count_reg - ECW'(1);

            if (cmd.pri_clear)
                pcount_reg <= '0;
            else if (cmd.pri_append)
                pcount_reg <= pcount_reg + PCW'(1);

            if (cmd.clr_pidx)
                pidx_reg <= '0;
            else if (cmd.inc_pidx)
                pidx_reg <= pidx_reg + PCW'(1);

            if (cmd.clr_pidx)
                pri_reg <= 1'b0;
            else if (cmd.pri_found)
                pri_reg <= 1'b1;

            // Settle gate, one-way
            if (cmd.gate_upd && !gate_reg)
            begin
                world_since_reg <= ws_eff;
                if (ws_eff != 32'd0 && settle_dt >= {16'd0, settle_reg})
                    gate_reg <= 1'b1;
            end

            if (cmd.tick_setup)
            begin
                budget_reg <= gate_reg ? budget_cfg_reg : 4'd0;
                bg_reg     <= gate_reg && (spacing_dt >= {16'd0, spacing_reg});
            end
            else if (cmd.issue)
            begin
                if (pri_reg)
                    budget_reg <= budget_reg - 4'd1;
                else
                begin
                    bg_reg         <= 1'b0;
                    last_issue_reg <= req_reg.now_ms;
                end
            end

            // Result buffering: the newest result waits in hold until its last flag is known
            if (cmd.emit)
                hold_valid_reg <= 1'b1;
            else if (cmd.flush)
                hold_valid_reg <= 1'b0;

            if ((cmd.emit && hold_valid_reg) || cmd.flush)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= in_data;
        if (cmd.load_e)
            e_reg <= ent_rdata_reg;
        else if (cmd.issue)
            e_reg.issued <= 1'b1;
        if (cmd.emit)
            hold_reg <= emit_word;
        if ((cmd.emit && hold_valid_reg) || cmd.flush)
            out_reg <= push_word;
    end

    // Status to controller
    assign pri_key = (req_reg.req_type == REQ_ADD_PRI) ? req_reg.item_id : e_reg.item;

    always_comb
    begin
        st             = '0;
        st.req_type    = req_reg.req_type;
        st.hit         = req_reg.cache_hit;
        st.impl        = req_reg.implicit;
        st.item_zero   = (req_reg.item_id == '0);
        st.idx_end     = (idx_reg >= count_reg);
        st.idx_is_last = (idx_reg == count_reg);
        st.ent_match   = (ent_rdata_reg.item == req_reg.item_id);
        st.ent_full    = (count_reg >= ECW'(PENDING_DEPTH));
        st.count_zero  = (count_reg == '0);
        st.pidx_end    = (pidx_reg >= pcount_reg);
        st.pri_match   = (pri_rdata_reg == pri_key);
        st.pri_full    = (pcount_reg >= PCW'(PRIORITY_DEPTH));
        st.gate_open   = gate_reg;
        st.e_issued    = e_reg.issued;
        st.e_loaded    = e_reg.loaded;
        st.e_failed    = e_reg.failed;
        st.e_timeout   = e_reg.issued && (e_reg.wait_cnt >= max_wait_reg);
        st.go          = pri_reg ? (budget_reg != 4'd0) : bg_reg;
        st.hold_valid  = hold_valid_reg;
        st.out_free    = out_free;
    end

endmodule
`default_nettype wire

>>> hw/rtl/throttled_request_tracker.sv
// Top level of the throttled request tracker: controller plus datapath.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  in_data   (trt_pkg::in_item_t)
//   output    out_valid/ out_stall out_data  (trt_pkg::out_item_t)
//   config    cfg_wr_en            cfg_index, cfg_wdata
//
// One transaction is worked at a time. Track on a cache miss, fill and reject
// scan the pending table one entry at a time. A tick sweeps every pending entry,
// searches the priority table for each unissued entry once the gate is open and
// moves the last entry into each completion's slot. Each result needs the
// output register free; a stall on the output holds the sweep. Reset clears all
// control state and sets config to defaults; tables hold no valid bits to clear.
`default_nettype none
module throttled_request_tracker #(
    parameter int PENDING_DEPTH  = trt_pkg::PENDING_DEPTH_DEF,
    parameter int PRIORITY_DEPTH = trt_pkg::PRIORITY_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire trt_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output trt_pkg::out_item_t                  out_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [trt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import trt_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic    busy;

    assign in_stall = busy;

    trt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .busy     (busy),
        .st       (st),
        .cmd      (cmd)
    );

    trt_dp #(
        .PENDING_DEPTH  (PENDING_DEPTH),
        .PRIORITY_DEPTH (PRIORITY_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire
